@@ sv/fwdp_pkg.sv @@
package fwdp_pkg;

    localparam int FIELD_LEN  = 16;
    localparam int INT_DIGITS = 10;
    localparam int FRAC_FIRST = 11;
    localparam int FRAC_LAST  = 13;
    localparam int FLAG_LOSS  = 14;
    localparam int FLAG_STR   = 15;
    localparam int GROUP_LEN  = 4;
    localparam int NUM_GROUPS = FIELD_LEN / GROUP_LEN;

    localparam int WORD_W     = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAG_W      = 44;
    localparam int VALUE_W    = 45;
    localparam int POS_W      = 5;
    localparam int SLOT_W     = 6;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    typedef logic [MAG_W-1:0] mag_t;

    // What one byte lane reports to the merge logic.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              minus;
        mag_t              term;
    } lane_res_t;

    // Decimal weight of each character position; the point and flag
    // characters carry no weight.
    function automatic mag_t weight_of(input int pos);
        mag_t w;
        begin
            case (pos)
                0:       w = 44'd1000000000000;
                1:       w = 44'd100000000000;
                2:       w = 44'd10000000000;
                3:       w = 44'd1000000000;
                4:       w = 44'd100000000;
                5:       w = 44'd10000000;
                6:       w = 44'd1000000;
                7:       w = 44'd100000;
                8:       w = 44'd10000;
                9:       w = 44'd1000;
                11:      w = 44'd100;
                12:      w = 44'd10;
                13:      w = 44'd1;
                default: w = '0;
            endcase
            return w;
        end
    endfunction

endpackage

@@ sv/fwdp_in_if.sv @@
interface fwdp_in_if;
    logic                          valid;
    logic                          ready;
    logic [fwdp_pkg::WORD_W-1:0]   bytes_low;
    logic [fwdp_pkg::WORD_W-1:0]   bytes_high;
    logic [fwdp_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, output bytes_low, output bytes_high,
                    output slot_index, input ready);
    modport sink (input valid, input bytes_low, input bytes_high,
                  input slot_index, output ready);
endinterface

@@ sv/fwdp_out_if.sv @@
interface fwdp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fwdp_pkg::VALUE_W-1:0]  value_milli;
    logic [fwdp_pkg::CHAR_W-1:0]          loss_lock_flag;
    logic [fwdp_pkg::CHAR_W-1:0]          strength_flag;
    logic [fwdp_pkg::POS_W-1:0]           bytes_consumed;
    logic [fwdp_pkg::SLOT_W-1:0]          slot_tag;

    modport source (output valid, output value_milli, output loss_lock_flag,
                    output strength_flag, output bytes_consumed,
                    output slot_tag, input ready);
    modport sink (input valid, input value_milli, input loss_lock_flag,
                  input strength_flag, input bytes_consumed,
                  input slot_tag, output ready);
endinterface

@@ sv/fwdp_lane.sv @@
module fwdp_lane (
    input  logic [fwdp_pkg::CHAR_W-1:0] ch_raw,
    input  logic                        masked,
    input  fwdp_pkg::mag_t              weight,
    input  logic                        sign_en,
    output fwdp_pkg::lane_res_t         res
);
    import fwdp_pkg::*;

    logic [CHAR_W-1:0]  ch;
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  diff;

    // Bytes at and after the first newline read as spaces.
    assign ch   = masked ? CH_SPACE : ch_raw;
    assign diff = ch - CH_ZERO;

    always_comb
    begin
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            digit = diff[DIGIT_W-1:0];
        end
        else
        begin
            digit = '0;
        end
    end

    assign res.ch    = ch;
    assign res.minus = sign_en && (ch == CH_MINUS);
    assign res.term  = weight * {{(MAG_W-DIGIT_W){1'b0}}, digit};
endmodule

@@ sv/fwdp_merge.sv @@
module fwdp_merge (
    input  logic                                clk,
    input  logic                                en,
    input  fwdp_pkg::mag_t                      terms [fwdp_pkg::FIELD_LEN],
    input  logic                                negative,
    output logic signed [fwdp_pkg::VALUE_W-1:0] value_milli
);
    import fwdp_pkg::*;

    mag_t group_reg  [NUM_GROUPS];
    mag_t group_next [NUM_GROUPS];
    logic neg_reg;
    mag_t total;
    logic signed [VALUE_W-1:0] value_next;
    logic signed [VALUE_W-1:0] value_reg;

    // First level: four lanes summed into each group register.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = terms[g*GROUP_LEN]   + terms[g*GROUP_LEN+1]
                          + terms[g*GROUP_LEN+2] + terms[g*GROUP_LEN+3];
        end
    end

    // Second level: group sums added and the sign applied.
    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            total = total + group_reg[g];
        end
        if (neg_reg)
        begin
            value_next = -$signed({1'b0, total});
        end
        else
        begin
            value_next = $signed({1'b0, total});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            group_reg <= group_next;
            neg_reg   <= negative;
            value_reg <= value_next;
        end
    end

    assign value_milli = value_reg;
endmodule

@@ sv/fixed_width_decimal_field_parse_top.sv @@
// Pipeline: an input beat passes three register stages, the first of which loads
// at the edge that accepts it; the last is the output register, from which its
// result beat shows on the output channel.
// Throughput: one field per cycle; the sixteen byte lanes and the two-level
// adder tree are fully pipelined, and the whole pipe stalls only while the
// output register holds a beat that has not been taken.
// Reset: rst_n clears the stage valid flags asynchronously; data is not reset.
module fixed_width_decimal_field_parse_top (
    input  logic       clk,
    input  logic       rst_n,
    fwdp_in_if.sink    field_in,
    fwdp_out_if.source result_out
);
    import fwdp_pkg::*;

    // Stage structure:
    //   stage 1: newline search, byte lanes, registered lane results.
    //   stage 2: group sums inside the merge unit.
    //   stage 3: final sum and sign, which is the output register.
    // All three stages advance together whenever the output register is
    // empty or its beat is being taken, so a new beat can enter every cycle.

    logic en;

    logic [CHAR_W-1:0]    ch_raw  [FIELD_LEN];
    logic [FIELD_LEN-1:0] nl_hit;
    logic [FIELD_LEN-1:0] mask;
    lane_res_t            lane_res [FIELD_LEN];
    logic [POS_W-1:0]     consumed_next;
    logic                 neg_next;

    logic                 v1_reg, v2_reg, v3_reg;
    mag_t                 term_reg [FIELD_LEN];
    logic                 neg_reg;
    logic [CHAR_W-1:0]    loss1_reg, loss2_reg, loss3_reg;
    logic [CHAR_W-1:0]    str1_reg,  str2_reg,  str3_reg;
    logic [POS_W-1:0]     cons1_reg, cons2_reg, cons3_reg;
    logic [SLOT_W-1:0]    slot1_reg, slot2_reg, slot3_reg;

    assign en             = !v3_reg || result_out.ready;
    assign field_in.ready = en;

    // Split the two words into characters and flag every newline.
    always_comb
    begin
        for (int i = 0; i < FIELD_LEN; i++)
        begin
            if (i < FIELD_LEN / 2)
            begin
                ch_raw[i] = field_in.bytes_low[i*CHAR_W +: CHAR_W];
            end
            else
            begin
                ch_raw[i] = field_in.bytes_high[(i - FIELD_LEN/2)*CHAR_W +: CHAR_W];
            end
            nl_hit[i] = (ch_raw[i] == CH_NEWLINE);
        end
    end

    // A byte is masked when a newline stands at or before it. The count of
    // unmasked bytes is then the offset of the first newline, or sixteen.
    always_comb
    begin
        mask[0] = nl_hit[0];
        for (int i = 1; i < FIELD_LEN; i++)
        begin
            mask[i] = mask[i-1] | nl_hit[i];
        end
        consumed_next = POS_W'($countones(~mask));
    end

    genvar gi;
    generate
        for (gi = 0; gi < FIELD_LEN; gi++)
        begin : g_lane
            fwdp_lane u_lane (
                .ch_raw  (ch_raw[gi]),
                .masked  (mask[gi]),
                .weight  (weight_of(gi)),
                .sign_en (gi < INT_DIGITS),
                .res     (lane_res[gi])
            );
        end
    endgenerate

    // Any minus sign among the integer characters negates the value.
    always_comb
    begin
        neg_next = 1'b0;
        for (int i = 0; i < FIELD_LEN; i++)
        begin
            neg_next = neg_next | lane_res[i].minus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= field_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Side fields ride along with the arithmetic through all three stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < FIELD_LEN; i++)
            begin
                term_reg[i] <= lane_res[i].term;
            end
            neg_reg   <= neg_next;
            loss1_reg <= lane_res[FLAG_LOSS].ch;
            str1_reg  <= lane_res[FLAG_STR].ch;
            cons1_reg <= consumed_next;
            slot1_reg <= field_in.slot_index;

            loss2_reg <= loss1_reg;
            str2_reg  <= str1_reg;
            cons2_reg <= cons1_reg;
            slot2_reg <= slot1_reg;

            loss3_reg <= loss2_reg;
            str3_reg  <= str2_reg;
            cons3_reg <= cons2_reg;
            slot3_reg <= slot2_reg;
        end
    end

    fwdp_merge u_merge (
        .clk         (clk),
        .en          (en),
        .terms       (term_reg),
        .negative    (neg_reg),
        .value_milli (result_out.value_milli)
    );

    assign result_out.valid          = v3_reg;
    assign result_out.loss_lock_flag = loss3_reg;
    assign result_out.strength_flag  = str3_reg;
    assign result_out.bytes_consumed = cons3_reg;
    assign result_out.slot_tag       = slot3_reg;
endmodule

@@ tb/testbench.sv @@
module testbench;

    import fwdp_pkg::*;

    // One field beat as the sender presents it.
    typedef struct packed {
        logic [WORD_W-1:0] bytes_low;
        logic [WORD_W-1:0] bytes_high;
        logic [SLOT_W-1:0] slot_index;
    } field_beat_t;

    // One parsed result beat as the block should return it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_milli;
        logic [CHAR_W-1:0]         loss_lock_flag;
        logic [CHAR_W-1:0]         strength_flag;
        logic [POS_W-1:0]          bytes_consumed;
        logic [SLOT_W-1:0]         slot_tag;
    } parsed_field_t;

    localparam int RANDOM_FIELDS = 1500;

    // Window, counted in cycles after reset, in which neither side stalls.
    localparam int CALM_FROM = 300;
    localparam int CALM_TO   = 1100;

    logic clk = 1'b0;
    logic rst_n;

    fwdp_in_if  field_in ();
    fwdp_out_if result_out ();

    fixed_width_decimal_field_parse_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .field_in   (field_in),
        .result_out (result_out)
    );

    field_beat_t   fields_to_send[$];
    parsed_field_t parses_due[$];
    field_beat_t   next_field;
    parsed_field_t oldest_parse;
    int            mismatch_count = 0;
    int            cycle_count;
    logic          calm;

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    // The expected parse of one field. The newline tail is blanked first, then
    // the integer and fraction digits are accumulated most significant first,
    // with anything that is not a decimal digit counting as zero. A minus in
    // the integer part negates the whole value; NUL bytes never do.
    function automatic parsed_field_t parse_field(field_beat_t beat);
        logic [FIELD_LEN*CHAR_W-1:0] text;
        logic [CHAR_W-1:0]           ch;
        logic [63:0]                 magnitude;
        logic                        negative;
        int                          newline_at;
        parsed_field_t               parsed;
        text = {beat.bytes_high, beat.bytes_low};
        newline_at = FIELD_LEN;
        for (int i = FIELD_LEN - 1; i >= 0; i--)
        begin
            if (text[CHAR_W*i +: CHAR_W] == CH_NEWLINE)
                newline_at = i;
        end
        for (int i = newline_at; i < FIELD_LEN; i++)
            text[CHAR_W*i +: CHAR_W] = CH_SPACE;
        magnitude = '0;
        negative = 1'b0;
        for (int i = 0; i <= FRAC_LAST; i++)
        begin
            // The decimal point position carries no weight.
            if (i == INT_DIGITS)
                continue;
            ch = text[CHAR_W*i +: CHAR_W];
            if (i < INT_DIGITS && ch == CH_MINUS)
                negative = 1'b1;
            if (ch >= CH_ZERO && ch <= CH_NINE)
                magnitude = magnitude * 10 + (ch - CH_ZERO);
            else
                magnitude = magnitude * 10;
        end
        parsed.value_milli = negative ? -magnitude[VALUE_W-1:0] : magnitude[VALUE_W-1:0];
        parsed.loss_lock_flag = text[CHAR_W*FLAG_LOSS +: CHAR_W];
        parsed.strength_flag = text[CHAR_W*FLAG_STR +: CHAR_W];
        parsed.bytes_consumed = newline_at[POS_W-1:0];
        parsed.slot_tag = beat.slot_index;
        return parsed;
    endfunction

    // Packs a text string into a field beat, character 0 in the lowest byte,
    // padding with spaces up to the full field width.
    function automatic field_beat_t text_beat(string s, logic [SLOT_W-1:0] slot);
        logic [FIELD_LEN*CHAR_W-1:0] raw;
        field_beat_t                 beat;
        raw = {FIELD_LEN{CH_SPACE}};
        for (int i = 0; i < s.len() && i < FIELD_LEN; i++)
            raw[CHAR_W*i +: CHAR_W] = s[i];
        beat.bytes_low = raw[WORD_W-1:0];
        beat.bytes_high = raw[FIELD_LEN*CHAR_W-1:WORD_W];
        beat.slot_index = slot;
        return beat;
    endfunction

    task automatic compare_field(string what, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, what, want, want, got, got);
            mismatch_count++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Cycles since reset; this only places the stretch without stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
    end

    // Driver. A beat taken at this edge gets its parse predicted from the
    // payload that was on the wires; then the next pending field is put up,
    // unless the sender chooses to idle instead. A beat that has not been
    // taken stays on the wires untouched.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_in.valid <= 1'b0;
        end
        else
        begin
            if (field_in.valid && field_in.ready)
                parses_due.push_back(parse_field({field_in.bytes_low, field_in.bytes_high,
                                                  field_in.slot_index}));
            if (!field_in.valid || field_in.ready)
            begin
                if (fields_to_send.size() != 0 && (calm || $urandom_range(99) >= 10))
                begin
                    next_field = fields_to_send.pop_front();
                    field_in.valid <= 1'b1;
                    field_in.bytes_low <= next_field.bytes_low;
                    field_in.bytes_high <= next_field.bytes_high;
                    field_in.slot_index <= next_field.slot_index;
                end
                else
                begin
                    field_in.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every result beat taken is checked field by field against the
    // oldest outstanding parse; ready is dropped at random to stall the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                if (parses_due.size() == 0)
                begin
                    $display("%0t: result beat with none expected, value_milli %0d slot %0d",
                             $time, result_out.value_milli, result_out.slot_tag);
                    mismatch_count++;
                end
                else
                begin
                    oldest_parse = parses_due.pop_front();
                    compare_field("value_milli", longint'($signed(oldest_parse.value_milli)),
                                  longint'($signed(result_out.value_milli)));
                    compare_field("loss_lock_flag", longint'(oldest_parse.loss_lock_flag),
                                  longint'(result_out.loss_lock_flag));
                    compare_field("strength_flag", longint'(oldest_parse.strength_flag),
                                  longint'(result_out.strength_flag));
                    compare_field("bytes_consumed", longint'(oldest_parse.bytes_consumed),
                                  longint'(result_out.bytes_consumed));
                    compare_field("slot_tag", longint'(oldest_parse.slot_tag),
                                  longint'(result_out.slot_tag));
                end
            end
            result_out.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // Stimulus, reset and the end of the run.
    initial
    begin
        field_beat_t                 beat;
        logic [FIELD_LEN*CHAR_W-1:0] raw;
        int                          lead;
        int                          pick;
        int                          drain;
        rst_n = 1'b0;
        field_in.valid = 1'b0;
        field_in.bytes_low = '0;
        field_in.bytes_high = '0;
        field_in.slot_index = '0;
        result_out.ready = 1'b0;

        // Directed fields: largest values of either sign, zero and negative
        // zero, leading blanks, a minus inside or after the digits, newlines
        // at the start, in the point and flag positions and repeated, carriage
        // returns, the neighbors of the digit codes, NUL and high bytes.
        fields_to_send.push_back(text_beat("9999999999.999AB", 0));
        fields_to_send.push_back(text_beat("-999999999.999 1", 63));
        fields_to_send.push_back(text_beat("0000000000.00000", 1));
        fields_to_send.push_back(text_beat("-000000000.000  ", 2));
        fields_to_send.push_back(text_beat("       123.456 0", 3));
        fields_to_send.push_back(text_beat("123-456789.123ZZ", 4));
        fields_to_send.push_back(text_beat("0000000123-456-1", 5));
        fields_to_send.push_back(text_beat("\n999999999.999AB", 6));
        fields_to_send.push_back(text_beat("12345\n6789.123XY", 7));
        fields_to_send.push_back(text_beat("0000000001.001\nB", 8));
        fields_to_send.push_back(text_beat("0000000001.001A\n", 9));
        fields_to_send.push_back(text_beat("0000000077\n123AB", 10));
        fields_to_send.push_back(text_beat("12\n-56789.123AB9", 11));
        fields_to_send.push_back(text_beat("-5\n\n\n0000000001", 12));
        fields_to_send.push_back(text_beat("12345\015789.1\015\015A", 13));
        fields_to_send.push_back(text_beat("9/:9 9.9:9/9.9 A", 14));
        fields_to_send.push_back('{64'h0, 64'h0, 6'd15});
        fields_to_send.push_back('{{WORD_W{1'b1}}, {WORD_W{1'b1}}, 6'd16});
        fields_to_send.push_back('{64'hB9B0_8039_3130_FFB9, 64'h8031_3233_2E2D_3980, 6'd17});
        fields_to_send.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 6'd42});
        // NUL bytes in the point, fraction and flag positions do not negate the
        // value; the second of these fields is negative through its integer minus.
        beat = text_beat("0000000042.5", 21);
        beat.bytes_high[WORD_W-1:2*CHAR_W] = '0;
        fields_to_send.push_back(beat);
        beat = text_beat("00000000-7", 22);
        beat.bytes_high[WORD_W-1:2*CHAR_W] = '0;
        fields_to_send.push_back(beat);

        // Random fields. Most are well formed numbers with random digits, a
        // random count of leading blanks and at times a minus, a newline or a
        // carriage return; the rest are raw random words or jumbles of the
        // characters that matter here.
        for (int n = 0; n < RANDOM_FIELDS; n++)
        begin
            raw = {FIELD_LEN{CH_SPACE}};
            if ($urandom_range(99) < 80)
            begin
                lead = $urandom_range(INT_DIGITS);
                for (int i = lead; i < INT_DIGITS; i++)
                    raw[CHAR_W*i +: CHAR_W] = CH_ZERO + CHAR_W'($urandom_range(9));
                raw[CHAR_W*INT_DIGITS +: CHAR_W] =
                    ($urandom_range(9) == 0) ? CHAR_W'($urandom) : ".";
                for (int i = FRAC_FIRST; i <= FRAC_LAST; i++)
                    raw[CHAR_W*i +: CHAR_W] = ($urandom_range(19) == 0) ? CH_SPACE :
                                              CH_ZERO + CHAR_W'($urandom_range(9));
                for (int i = FLAG_LOSS; i <= FLAG_STR; i++)
                begin
                    pick = $urandom_range(4);
                    raw[CHAR_W*i +: CHAR_W] = (pick == 0) ? "0" : (pick == 1) ? "1" :
                                              (pick == 2) ? CH_SPACE : (pick == 3) ? "A" :
                                              CHAR_W'($urandom);
                end
                if ($urandom_range(99) < 30)
                begin
                    if (lead > 0 && $urandom_range(1) == 0)
                        raw[CHAR_W*(lead-1) +: CHAR_W] = CH_MINUS;
                    else
                        raw[CHAR_W*$urandom_range(FIELD_LEN-1) +: CHAR_W] = CH_MINUS;
                end
                if ($urandom_range(99) < 15)
                    raw[CHAR_W*$urandom_range(FIELD_LEN-1) +: CHAR_W] = CH_NEWLINE;
                if ($urandom_range(99) < 3)
                    raw[CHAR_W*$urandom_range(FIELD_LEN-1) +: CHAR_W] = 8'h0D;
            end
            else if ($urandom_range(1) == 0)
            begin
                raw = {$urandom, $urandom, $urandom, $urandom};
            end
            else
            begin
                for (int i = 0; i < FIELD_LEN; i++)
                begin
                    pick = $urandom_range(7);
                    raw[CHAR_W*i +: CHAR_W] = (pick == 0) ? CH_MINUS : (pick == 1) ? CH_NEWLINE :
                                              (pick == 2) ? 8'h00 : (pick == 3) ? CH_SPACE :
                                              (pick == 4) ? CHAR_W'($urandom) :
                                              CH_ZERO + CHAR_W'($urandom_range(9));
                end
            end
            beat.bytes_low = raw[WORD_W-1:0];
            beat.bytes_high = raw[FIELD_LEN*CHAR_W-1:WORD_W];
            beat.slot_index = SLOT_W'($urandom_range(63));
            fields_to_send.push_back(beat);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last beat to be taken, then for the pipe to drain.
        while (fields_to_send.size() != 0 || field_in.valid)
            @(posedge clk);
        drain = 0;
        while (parses_due.size() != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (parses_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, parses_due.size());
            mismatch_count += parses_due.size();
        end
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #3000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
